// File: hw/rtl/efla_pkg.sv
// Shared types, constants and helpers for the free-list heap allocator.
// Depends on nothing; imported by explicit_free_list_allocator.
package efla_pkg;

  localparam int HEAP_BYTES  = 65536;
  localparam int CHUNK_BYTES = 4096;
  localparam int NWORDS      = HEAP_BYTES / 4;
  localparam int WIDX_W      = $clog2(NWORDS);
  localparam int WALK_LIMIT  = HEAP_BYTES / 16 + 1;
  localparam int WALK_W      = $clog2(WALK_LIMIT + 1);
  localparam int HEAP_W      = $clog2(HEAP_BYTES + 1);

  localparam logic [31:0] ROOT_BP  = 32'd8;
  localparam logic [31:0] FIRST_BP = 32'd24;
  localparam logic [31:0] PRO_TAG  = 32'd17;
  localparam logic [31:0] EPI_TAG  = 32'd1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [16:0] request_size;
    logic [15:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_address;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [57:0] {
    S_CLR   = 58'b1 << 0,  S_INIT0 = 58'b1 << 1,  S_INIT1 = 58'b1 << 2,
    S_INIT2 = 58'b1 << 3,  S_IDLE  = 58'b1 << 4,  S_FF0   = 58'b1 << 5,
    S_FF1   = 58'b1 << 6,  S_FF2   = 58'b1 << 7,  S_FF3   = 58'b1 << 8,
    S_FF4   = 58'b1 << 9,  S_AGROWN = 58'b1 << 10, S_PL0  = 58'b1 << 11,
    S_PL1   = 58'b1 << 12, S_PLS1  = 58'b1 << 13, S_PLS2  = 58'b1 << 14,
    S_PLS3  = 58'b1 << 15, S_PLN1  = 58'b1 << 16, S_PLN2  = 58'b1 << 17,
    S_AFIN  = 58'b1 << 18, S_FR0   = 58'b1 << 19, S_FR1   = 58'b1 << 20,
    S_FR2   = 58'b1 << 21, S_FFIN  = 58'b1 << 22, S_G0    = 58'b1 << 23,
    S_G1    = 58'b1 << 24, S_G2    = 58'b1 << 25, S_M0    = 58'b1 << 26,
    S_M1    = 58'b1 << 27, S_M2    = 58'b1 << 28, S_M3    = 58'b1 << 29,
    S_M4    = 58'b1 << 30, S_M5    = 58'b1 << 31, S_MA0   = 58'b1 << 32,
    S_MA1   = 58'b1 << 33, S_MA2   = 58'b1 << 34, S_MB0   = 58'b1 << 35,
    S_MB1   = 58'b1 << 36, S_MB2   = 58'b1 << 37, S_MB3   = 58'b1 << 38,
    S_MC0   = 58'b1 << 39, S_MC1   = 58'b1 << 40, S_MC2   = 58'b1 << 41,
    S_MC3   = 58'b1 << 42, S_MC4   = 58'b1 << 43, S_MC5   = 58'b1 << 44,
    S_MC6   = 58'b1 << 45, S_P0    = 58'b1 << 46, S_P1    = 58'b1 << 47,
    S_P2    = 58'b1 << 48, S_P3    = 58'b1 << 49, S_P4    = 58'b1 << 50,
    S_P5    = 58'b1 << 51, S_U0    = 58'b1 << 52, S_U1    = 58'b1 << 53,
    S_U2    = 58'b1 << 54, S_U3    = 58'b1 << 55, S_U4    = 58'b1 << 56,
    S_U5    = 58'b1 << 57
  } state_t;

  // Block size held in a boundary tag, with the flag bits masked off.
  function automatic logic [31:0] bsz(input logic [31:0] w);
    return {w[31:3], 3'b000};
  endfunction

  // Word index of a byte address, wrapping at the heap size.
  function automatic logic [WIDX_W-1:0] widx(input logic [31:0] a);
    return a[WIDX_W+1:2];
  endfunction

endpackage

// File: hw/rtl/explicit_free_list_allocator.sv
// Free-list heap allocator: a sequencer over one word memory with a registered read port.
// Depends on efla_pkg. Zero-size allocate and out-of-range free are answered straight from
// idle; allocate walks the free list from the newest free block and grows the heap when no
// block fits. One item at a time, paced by the single memory port. Reset clears the heap
// memory, then builds the initial layout, with busy high throughout. The receiver cannot
// stall results.
module explicit_free_list_allocator
  import efla_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  cmd,
  output logic      busy,
  output logic      done,
  output out_item_t rsp
);

  logic [31:0] mem [NWORDS];
  logic [31:0] rdat;

  state_t state, ret_u, ret_p, ret_m, ret_g;

  logic [WIDX_W-1:0] clr_idx;
  logic [HEAP_W-1:0] heap_end;
  logic [WALK_W-1:0] wcnt;
  logic [31:0] bp, asize, csize, gbytes, gsz;
  logic [31:0] mbp, prv, nxt, msize, mres, pa_tag;
  logic [31:0] parg, uarg, ut;

  logic        we;
  logic [31:0] waddr, wdata, raddr;
  logic [31:0] he32, gsz_c, rsz;
  logic        gfail, split;

  assign he32  = 32'(heap_end);
  assign rsz   = bsz(rdat);
  assign gsz_c = {gbytes[31:3] + 29'(gbytes[2]), 3'b000};
  assign gfail = gsz_c > (32'(HEAP_BYTES) - he32);
  assign split = (rsz >= asize) && ((rsz - asize) >= 32'd16);
  assign busy  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[widx(waddr)] <= wdata;
    end
    rdat <= mem[widx(raddr)];
  end

  // Memory port control.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state)
      S_CLR:   begin we = 1'b1; waddr = {{(30-WIDX_W){1'b0}}, clr_idx, 2'b00}; end
      S_INIT0: begin we = 1'b1; waddr = 32'd4;  wdata = PRO_TAG; end
      S_INIT1: begin we = 1'b1; waddr = 32'd16; wdata = PRO_TAG; end
      S_INIT2: begin we = 1'b1; waddr = 32'd20; wdata = EPI_TAG; end
      S_IDLE, S_FF1, S_FF4, S_AGROWN, S_AFIN, S_FFIN, S_M5, S_MC0: begin end
      S_FF0:   raddr = ROOT_BP;
      S_FF2:   raddr = bp - 32'd4;
      S_FF3:   raddr = bp;
      S_PL0:   raddr = bp - 32'd4;
      S_PL1: begin
        if (split) begin
          we = 1'b1; waddr = bp - 32'd4; wdata = asize | 32'd1;
        end
      end
      S_PLS1:  begin we = 1'b1; waddr = bp + asize - 32'd8; wdata = asize | 32'd1; end
      S_PLS2:  begin we = 1'b1; waddr = bp + asize - 32'd4; wdata = csize - asize; end
      S_PLS3:  begin we = 1'b1; waddr = bp + csize - 32'd8; wdata = csize - asize; end
      S_PLN1:  begin we = 1'b1; waddr = bp - 32'd4; wdata = csize | 32'd1; end
      S_PLN2:  begin we = 1'b1; waddr = bp + csize - 32'd8; wdata = csize | 32'd1; end
      S_FR0:   raddr = mbp - 32'd4;
      S_FR1:   begin we = 1'b1; waddr = mbp - 32'd4; wdata = rsz; end
      S_FR2:   begin we = 1'b1; waddr = mbp + msize - 32'd8; wdata = msize; end
      S_G0: begin
        if (!gfail) begin
          we = 1'b1; waddr = he32 - 32'd4; wdata = gsz_c;
        end
      end
      S_G1:    begin we = 1'b1; waddr = he32 + gsz - 32'd8; wdata = gsz; end
      S_G2:    begin we = 1'b1; waddr = he32 + gsz - 32'd4; wdata = EPI_TAG; end
      S_M0:    raddr = mbp - 32'd8;
      S_M1:    raddr = mbp - rsz - 32'd4;
      S_M2:    raddr = prv + rsz - 32'd8;
      S_M3:    raddr = mbp - 32'd4;
      S_M4:    raddr = mbp + rsz - 32'd4;
      S_MA0:   raddr = nxt - 32'd4;
      S_MA1:   begin we = 1'b1; waddr = mbp - 32'd4; wdata = msize + rsz; end
      S_MA2:   begin we = 1'b1; waddr = mbp + msize - 32'd8; wdata = msize; end
      S_MB0:   raddr = prv - 32'd4;
      S_MB1:   raddr = mbp - 32'd4;
      S_MB2:   begin we = 1'b1; waddr = mbp + rsz - 32'd8; wdata = msize; end
      S_MB3:   begin we = 1'b1; waddr = prv - 32'd4; wdata = msize; end
      S_MC1:   raddr = prv - 32'd4;
      S_MC2:   raddr = nxt - 32'd4;
      S_MC3:   raddr = nxt + rsz - 32'd8;
      S_MC4:   begin we = 1'b1; waddr = prv - 32'd4; wdata = msize + rsz; end
      S_MC5:   raddr = nxt - 32'd4;
      S_MC6:   begin we = 1'b1; waddr = nxt + rsz - 32'd8; wdata = msize; end
      S_P0:    raddr = ROOT_BP;
      S_P1: begin
        if (rdat != 32'd0) begin
          we = 1'b1; waddr = rdat + 32'd4; wdata = parg;
        end
      end
      S_P2:    raddr = ROOT_BP;
      S_P3:    begin we = 1'b1; waddr = parg; wdata = rdat; end
      S_P4:    begin we = 1'b1; waddr = parg + 32'd4; wdata = ROOT_BP; end
      S_P5:    begin we = 1'b1; waddr = ROOT_BP; wdata = parg; end
      S_U0:    raddr = uarg;
      S_U1:    raddr = uarg + 32'd4;
      S_U2: begin
        if (ut != 32'd0) begin
          we = 1'b1; waddr = ut + 32'd4; wdata = rdat;
        end
      end
      S_U3:    raddr = uarg + 32'd4;
      S_U4:    raddr = uarg;
      S_U5:    begin we = 1'b1; waddr = ut; wdata = rdat; end
      default: begin end
    endcase
  end

  // Sequencer. Unlink, push, merge and grow are shared routines with their own return state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_idx  <= '0;
      heap_end <= HEAP_W'(FIRST_BP);
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (&clr_idx) begin
            state <= S_INIT0;
          end
        end
        S_INIT0: state <= S_INIT1;
        S_INIT1: state <= S_INIT2;
        S_INIT2: begin
          gbytes <= 32'(CHUNK_BYTES);
          ret_g  <= S_IDLE;
          state  <= S_G0;
        end
        S_IDLE: begin
          if (start) begin
            if (cmd.opcode == OP_ALLOC) begin
              if (cmd.request_size == '0) begin
                done  <= 1'b1;
                rsp   <= '{result_address: '0, status: ST_ZERO};
              end else begin
                asize <= (cmd.request_size <= 17'd8) ? 32'd16
                         : ((32'(cmd.request_size) + 32'd15) & ~32'd7);
                state <= S_FF0;
              end
            end else begin
              if (32'(cmd.block_address) >= FIRST_BP && 32'(cmd.block_address) < he32) begin
                mbp   <= 32'(cmd.block_address);
                state <= S_FR0;
              end else begin
                done <= 1'b1;
                rsp  <= '{result_address: '0, status: ST_OK};
              end
            end
          end
        end
        S_FF0: state <= S_FF1;
        S_FF1: begin
          bp    <= rdat;
          wcnt  <= '0;
          state <= S_FF2;
        end
        S_FF2: begin
          if (bp == 32'd0 || wcnt == WALK_W'(WALK_LIMIT)) begin
            gbytes <= (asize > 32'(CHUNK_BYTES)) ? asize : 32'(CHUNK_BYTES);
            ret_g  <= S_AGROWN;
            state  <= S_G0;
          end else begin
            state <= S_FF3;
          end
        end
        S_FF3: state <= (asize <= rsz) ? S_PL0 : S_FF4;
        S_FF4: begin
          bp    <= rdat;
          wcnt  <= wcnt + 1'b1;
          state <= S_FF2;
        end
        S_AGROWN: begin
          if (mres == 32'd0) begin
            done  <= 1'b1;
            rsp   <= '{result_address: '0, status: ST_OOM};
            state <= S_IDLE;
          end else begin
            bp    <= mres;
            state <= S_PL0;
          end
        end
        S_PL0: state <= S_PL1;
        S_PL1: begin
          csize <= rsz;
          if (split) begin
            state <= S_PLS1;
          end else begin
            uarg  <= bp;
            ret_u <= S_PLN1;
            state <= S_U0;
          end
        end
        S_PLS1: begin
          uarg  <= bp;
          ret_u <= S_PLS2;
          state <= S_U0;
        end
        S_PLS2: state <= S_PLS3;
        S_PLS3: begin
          parg  <= bp + asize;
          ret_p <= S_AFIN;
          state <= S_P0;
        end
        S_PLN1: state <= S_PLN2;
        S_PLN2: state <= S_AFIN;
        S_AFIN: begin
          done  <= 1'b1;
          rsp   <= '{result_address: bp[15:0], status: ST_OK};
          state <= S_IDLE;
        end
        S_FR0: state <= S_FR1;
        S_FR1: begin
          msize <= rsz;
          state <= S_FR2;
        end
        S_FR2: begin
          ret_m <= S_FFIN;
          state <= S_M0;
        end
        S_FFIN: begin
          done  <= 1'b1;
          rsp   <= '{result_address: '0, status: ST_OK};
          state <= S_IDLE;
        end
        S_G0: begin
          if (gfail) begin
            mres  <= 32'd0;
            state <= ret_g;
          end else begin
            gsz   <= gsz_c;
            state <= S_G1;
          end
        end
        S_G1: state <= S_G2;
        S_G2: begin
          mbp      <= he32;
          heap_end <= heap_end + gsz[HEAP_W-1:0];
          ret_m    <= ret_g;
          state    <= S_M0;
        end
        S_M0: state <= S_M1;
        S_M1: begin
          prv   <= mbp - rsz;
          state <= S_M2;
        end
        S_M2: state <= S_M3;
        S_M3: begin
          pa_tag <= rdat;
          state  <= S_M4;
        end
        S_M4: begin
          msize <= rsz;
          nxt   <= mbp + rsz;
          state <= S_M5;
        end
        S_M5: begin
          // Four neighbour cases, selected by the allocated bits either side.
          priority if (pa_tag[0] && rdat[0]) begin
            mres  <= mbp;
            parg  <= mbp;
            ret_p <= ret_m;
            state <= S_P0;
          end else if (pa_tag[0]) begin
            uarg  <= nxt;
            ret_u <= S_MA0;
            state <= S_U0;
          end else if (rdat[0]) begin
            uarg  <= prv;
            ret_u <= S_MB0;
            state <= S_U0;
          end else begin
            uarg  <= nxt;
            ret_u <= S_MC0;
            state <= S_U0;
          end
        end
        S_MA0: state <= S_MA1;
        S_MA1: begin
          msize <= msize + rsz;
          state <= S_MA2;
        end
        S_MA2: begin
          mres  <= mbp;
          parg  <= mbp;
          ret_p <= ret_m;
          state <= S_P0;
        end
        S_MB0: state <= S_MB1;
        S_MB1: begin
          msize <= msize + rsz;
          state <= S_MB2;
        end
        S_MB2: state <= S_MB3;
        S_MB3: begin
          mres  <= prv;
          parg  <= prv;
          ret_p <= ret_m;
          state <= S_P0;
        end
        S_MC0: begin
          uarg  <= prv;
          ret_u <= S_MC1;
          state <= S_U0;
        end
        S_MC1: state <= S_MC2;
        S_MC2: begin
          msize <= msize + rsz;
          state <= S_MC3;
        end
        S_MC3: state <= S_MC4;
        S_MC4: begin
          msize <= msize + rsz;
          state <= S_MC5;
        end
        S_MC5: state <= S_MC6;
        S_MC6: begin
          mres  <= prv;
          parg  <= prv;
          ret_p <= ret_m;
          state <= S_P0;
        end
        S_P0: state <= S_P1;
        S_P1: state <= S_P2;
        S_P2: state <= S_P3;
        S_P3: state <= S_P4;
        S_P4: state <= S_P5;
        S_P5: state <= ret_p;
        S_U0: state <= S_U1;
        S_U1: begin
          ut    <= rdat;
          state <= S_U2;
        end
        S_U2: state <= S_U3;
        S_U3: state <= S_U4;
        S_U4: begin
          // The newer link is read again, as the first write may have touched it.
          ut    <= rdat;
          state <= (rdat == 32'd0) ? ret_u : S_U5;
        end
        S_U5: state <= ret_u;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while the sequencer is still working");

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither started nor answered");

  a_heap_end: assert property (@(posedge clk) disable iff (rst)
    (32'(heap_end) <= 32'(HEAP_BYTES)) && (heap_end[2:0] == 3'b000))
    else $error("heap end out of range or misaligned");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FF4) |-> (32'(wcnt) < 32'(WALK_LIMIT)))
    else $error("free-list walk ran past its bound");

endmodule
